@@ rtl/core/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache: field width,
// operation codes and the control bundle passed along the cell row.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	// Width of the key and value fields on the ports
	localparam int FIELD_BITS = 32;

	// Operation codes on func
	localparam logic FUNC_PUT = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	// Control handed from one cell to the next
	typedef struct packed {
		logic upd;   // this beat changes the store
		logic seen;  // a key match was found in a more recent cell
	} cell_ctl_t;

endpackage

@@ rtl/core/lkvc_cell.sv @@
// ----------------------------------------------------------------------------
// lkvc_cell
// One entry of the recency-ordered cell row. It compares its key against the
// request and, on an update with no match in a more recent cell, takes the entry of its more recent neighbor.
// ----------------------------------------------------------------------------
module lkvc_cell #(
	parameter int KW = 32,
	parameter int VW = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lkvc_pkg::cell_ctl_t    ctl_in,
	input  logic [KW-1:0]          req_key,
	input  logic [KW-1:0]          prev_key,
	input  logic [VW-1:0]          prev_value,
	input  logic                   prev_valid,
	output lkvc_pkg::cell_ctl_t    ctl_out,
	output logic [KW-1:0]          key,
	output logic [VW-1:0]          value,
	output logic                   valid,
	output logic                   match
);
	import lkvc_pkg::*;

	logic [KW-1:0] key_q;
	logic [VW-1:0] value_q;
	logic          valid_q;
	logic          load;

	// Compare against the request
	assign match = valid_q && (key_q == req_key);

	// Pass the match flag down the row
	assign ctl_out.upd  = ctl_in.upd;
	assign ctl_out.seen = ctl_in.seen | match;

	// Shift every cell up to and including the matching one
	assign load = ctl_in.upd & ~ctl_in.seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign valid = valid_q;

endmodule

@@ rtl/core/lru_key_value_cache_unit.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The store is a row of CAPACITY cells kept in recency order: the first cell
// holds the most recent entry and the last one the least recent. Each beat is
// held in the request register, then every cell compares its key in parallel, and
// on a hit or a put the cells ahead of the matching one (or the whole row on a
// put miss) move one place down while the touched entry enters at the front.
// A put miss on a full row pushes the last cell out and reports its key. The
// result is held in the result register, and a new beat is taken every
// cycle while the result side does not stall; the cycle time is set by the
// match flag rippling down the cell row. Valid marks clear at reset.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [lkvc_pkg::FIELD_BITS-1:0] lookup_key,
	input  logic [lkvc_pkg::FIELD_BITS-1:0] put_value,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic [lkvc_pkg::FIELD_BITS-1:0] get_value,
	output logic                            evicted,
	output logic [lkvc_pkg::FIELD_BITS-1:0] evicted_key
);
	import lkvc_pkg::*;

	// Bits beyond the port width are always zero, so they need no storage
	localparam int KW = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
	localparam int VW = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

	logic          busy_q;
	logic          req_func_q;
	logic [KW-1:0] req_key_q;
	logic [VW-1:0] req_value_q;

	logic                  out_valid_q;
	logic                  hit_q;
	logic [FIELD_BITS-1:0] get_value_q;
	logic                  evicted_q;
	logic [FIELD_BITS-1:0] evicted_key_q;

	logic          exec;
	logic          take;
	logic          any_hit;
	logic          is_put;
	logic [VW-1:0] hit_value;
	logic [VW-1:0] front_value;

	cell_ctl_t     ctl     [CAPACITY+1];
	logic [KW-1:0] c_key   [CAPACITY];
	logic [VW-1:0] c_value [CAPACITY];
	logic          c_valid [CAPACITY];
	logic          c_match [CAPACITY];

	// Handshake: execute the held beat when the result register is free
	assign exec     = busy_q & (~out_valid_q | ~out_stall);
	assign in_stall = busy_q & ~exec;
	assign take     = in_valid & ~in_stall;

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_func_q  <= func;
			req_key_q   <= lookup_key[KW-1:0];
			req_value_q <= put_value[VW-1:0];
		end
	end

	// Row control: update on any hit or on any put
	assign is_put      = (req_func_q == FUNC_PUT);
	assign any_hit     = ctl[CAPACITY].seen;
	assign ctl[0].upd  = exec & (any_hit | is_put);
	assign ctl[0].seen = 1'b0;

	// Select the value of the matching cell (at most one matches)
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_value = hit_value | (c_value[i] & {VW{c_match[i]}});
		end
	end

	// Touched entry enters at the front with the new or the kept value
	assign front_value = is_put ? req_value_q : hit_value;

	// Cell row, most recent first
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_front
			lkvc_cell #(.KW(KW), .VW(VW)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl_in     (ctl[g]),
				.req_key    (req_key_q),
				.prev_key   (req_key_q),
				.prev_value (front_value),
				.prev_valid (1'b1),
				.ctl_out    (ctl[g+1]),
				.key        (c_key[g]),
				.value      (c_value[g]),
				.valid      (c_valid[g]),
				.match      (c_match[g])
			);
		end else begin : g_rest
			lkvc_cell #(.KW(KW), .VW(VW)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl_in     (ctl[g]),
				.req_key    (req_key_q),
				.prev_key   (c_key[g-1]),
				.prev_value (c_value[g-1]),
				.prev_valid (c_valid[g-1]),
				.ctl_out    (ctl[g+1]),
				.key        (c_key[g]),
				.value      (c_value[g]),
				.valid      (c_valid[g]),
				.match      (c_match[g])
			);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			hit_q         <= any_hit;
			get_value_q   <= (any_hit && !is_put) ?
				FIELD_BITS'(hit_value) : '0;
			evicted_q     <= is_put & ~any_hit & c_valid[CAPACITY-1];
			evicted_key_q <= (is_put && !any_hit && c_valid[CAPACITY-1]) ?
				FIELD_BITS'(c_key[CAPACITY-1]) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign get_value   = get_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule

@@ tb/lru_key_value_cache_checker.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// Watches both channels of the LRU key/value cache. Each accepted request
// beat runs through a private copy of the store to work out the reply. Each
// accepted reply beat is compared field by field with the oldest reply
// still waiting.
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            func,
	input  logic [lkvc_pkg::FIELD_BITS-1:0] lookup_key,
	input  logic [lkvc_pkg::FIELD_BITS-1:0] put_value,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            hit,
	input  logic [lkvc_pkg::FIELD_BITS-1:0] get_value,
	input  logic                            evicted,
	input  logic [lkvc_pkg::FIELD_BITS-1:0] evicted_key,
	output int                              mismatch_count,
	output int                              replies_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import lkvc_pkg::*;

	localparam int SLOTS      = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int DUE_DEPTH  = 64;

	typedef struct packed {
		logic                  hit;
		logic [FIELD_BITS-1:0] get_value;
		logic                  evicted;
		logic [FIELD_BITS-1:0] evicted_key;
	} cache_reply_t;

	// Private copy of the store; age 0 is the most recent entry
	logic [KEY_BITS-1:0]   slot_key   [SLOTS];
	logic [VALUE_BITS-1:0] slot_value [SLOTS];
	bit                    slot_used  [SLOTS];
	int unsigned           slot_age   [SLOTS];

	// Replies still waiting, oldest at due_head
	cache_reply_t          due_buf [DUE_DEPTH];
	logic [5:0]            due_head;
	logic [5:0]            due_tail;
	int                    due_count;

	// Move one slot to the front; the slots ahead of it age by one
	function automatic void make_newest(int idx);
		int unsigned old_age;
		old_age = slot_age[idx];
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i] && slot_age[i] < old_age)
				slot_age[i]++;
		slot_age[idx] = 0;
	endfunction

	// Apply one put or get to the store and return the reply it causes
	function automatic cache_reply_t access_store(logic op, logic [FIELD_BITS-1:0] key_in,
			logic [FIELD_BITS-1:0] value_in);
		cache_reply_t        reply;
		logic [KEY_BITS-1:0] key;
		int                  match_idx;
		int                  free_idx;
		int                  victim_idx;
		int unsigned         oldest;
		reply      = '0;
		key        = key_in[KEY_BITS-1:0];
		match_idx  = -1;
		free_idx   = -1;
		victim_idx = 0;
		oldest     = 0;
		// search valid slots for the key and the oldest entry, note the first hole
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_used[i]) begin
				if (match_idx < 0 && slot_key[i] == key)
					match_idx = i;
				if (slot_age[i] >= oldest) begin
					oldest     = slot_age[i];
					victim_idx = i;
				end
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (match_idx >= 0) begin
			reply.hit = 1'b1;
			if (op == FUNC_GET)
				reply.get_value = FIELD_BITS'(slot_value[match_idx]);
			else
				slot_value[match_idx] = value_in[VALUE_BITS-1:0];
			make_newest(match_idx);
		end else if (op == FUNC_PUT) begin
			if (free_idx >= 0) begin
				// fill the lowest hole, everything else ages
				for (int i = 0; i < SLOTS; i++)
					if (slot_used[i])
						slot_age[i]++;
				slot_used[free_idx]  = 1'b1;
				slot_key[free_idx]   = key;
				slot_value[free_idx] = value_in[VALUE_BITS-1:0];
				slot_age[free_idx]   = 0;
			end else begin
				// full: replace the least recent entry in place
				reply.evicted         = 1'b1;
				reply.evicted_key     = FIELD_BITS'(slot_key[victim_idx]);
				slot_key[victim_idx]   = key;
				slot_value[victim_idx] = value_in[VALUE_BITS-1:0];
				make_newest(victim_idx);
			end
		end
		return reply;
	endfunction

	function automatic void check_field(string name, logic [FIELD_BITS-1:0] want,
			logic [FIELD_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Predict on request beats, compare on reply beats
	always @(posedge clk or negedge arst_n) begin : watch
		cache_reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_key[i]   = '0;
				slot_value[i] = '0;
				slot_used[i]  = 1'b0;
				slot_age[i]   = 0;
			end
			due_head  = '0;
			due_tail  = '0;
			due_count = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (due_count == DUE_DEPTH) begin
					$error("too many replies waiting");
					mismatch_count++;
				end else begin
					due_buf[due_tail] = access_store(func, lookup_key, put_value);
					due_tail++;
					due_count++;
				end
			end
			if (out_valid && !out_stall) begin
				if (due_count == 0) begin
					$error("reply beat with no request waiting");
					mismatch_count++;
				end else begin
					want = due_buf[due_head];
					due_head++;
					due_count--;
					check_field("hit", FIELD_BITS'(want.hit), FIELD_BITS'(hit));
					check_field("get_value", want.get_value, get_value);
					check_field("evicted", FIELD_BITS'(want.evicted), FIELD_BITS'(evicted));
					check_field("evicted_key", want.evicted_key, evicted_key);
				end
			end
		end
		replies_pending = due_count;
	end

endmodule

@@ tb/tb_lru_key_value_cache_unit.sv @@
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// Drives puts and gets into the LRU key/value cache: a directed pass over
// empty, filling, hit, overwrite and eviction cases, then random requests
// drawn mostly from a small key pool so that hits and evictions are common.
// Both sides idle at random; the reply side also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lkvc_pkg::*;

	localparam int RANDOM_REQUESTS = 2000;
	localparam int KEY_POOL        = 24;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_START      = 1500;
	localparam int HOLD_CYCLES     = 120;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  func        = FUNC_PUT;
	logic [FIELD_BITS-1:0] lookup_key  = '0;
	logic [FIELD_BITS-1:0] put_value   = '0;
	logic                  out_stall   = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic                  hit;
	logic [FIELD_BITS-1:0] get_value;
	logic                  evicted;
	logic [FIELD_BITS-1:0] evicted_key;

	int                    mismatch_count;
	int                    replies_pending;
	int                    cycle_count = 0;
	bit                    sender_busy = 1'b0;
	logic [FIELD_BITS-1:0] key_pool[KEY_POOL];

	initial begin
		forever #4 clk = ~clk;
	end

	lru_key_value_cache_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.lookup_key  (lookup_key),
		.put_value   (put_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.get_value   (get_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	lru_key_value_cache_checker cache_watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.lookup_key      (lookup_key),
		.put_value       (put_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.hit             (hit),
		.get_value       (get_value),
		.evicted         (evicted),
		.evicted_key     (evicted_key),
		.mismatch_count  (mismatch_count),
		.replies_pending (replies_pending)
	);

	// Offer one request beat, after random idle cycles, and hold it until taken
	task automatic offer_request(logic op, logic [FIELD_BITS-1:0] key_in,
			logic [FIELD_BITS-1:0] value_in);
		while (!sender_busy && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= op;
		lookup_key <= key_in;
		put_value  <= value_in;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stall replies at random, with one long hold-off and one calm stretch
	initial begin : reply_side
		int hold_left;
		int rx_cycle;
		hold_left = 0;
		rx_cycle  = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle == HOLD_START)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (rx_cycle >= 2500 && rx_cycle < 3000) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 27);
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[lru_key_value_cache_unit] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int                    pick;
		logic [FIELD_BITS-1:0] key_sel;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < KEY_POOL; i++)
			key_pool[i] = $urandom;

		// gets on an empty store miss
		offer_request(FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		offer_request(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		// extreme keys and values, then hits and an overwrite
		offer_request(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		offer_request(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		offer_request(FUNC_GET, 32'h0000_0000, 32'h5555_5555);
		offer_request(FUNC_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
		offer_request(FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
		// fill the remaining slots
		for (int i = 1; i <= 14; i++)
			offer_request(FUNC_PUT, i, ~i);
		// touch a middle entry, then evict twice and look for a victim
		offer_request(FUNC_GET, 32'd5, 32'd0);
		offer_request(FUNC_PUT, 32'd100, 32'hCAFE_0001);
		offer_request(FUNC_GET, 32'hFFFF_FFFF, 32'd0);
		offer_request(FUNC_PUT, 32'd101, 32'hCAFE_0002);

		// random puts and gets, mostly on pool keys
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			sender_busy = (n >= 1000 && n < 1300);
			pick = $urandom_range(99);
			if (pick < 85)
				key_sel = key_pool[$urandom_range(KEY_POOL - 1)];
			else
				key_sel = $urandom;
			offer_request(1'($urandom_range(1)), key_sel, $urandom);
		end
		in_valid <= 1'b0;

		// let the checker log the last beat, drain replies, then wait a little
		@(posedge clk);
		wait (replies_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[lru_key_value_cache_unit] OK");
		else
			$display("[lru_key_value_cache_unit] ERROR");
		$finish;
	end

endmodule
